// File: design/cascaded_fixed_point_iir_filter_defines.svh
// Assertion macros for the cascaded fixed-point IIR filter.
`ifndef CASCADED_FIXED_POINT_IIR_FILTER_DEFINES_SVH
`define CASCADED_FIXED_POINT_IIR_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define CFPIIR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define CFPIIR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CFPIIR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CFPIIR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: design/cfpiir_pkg.sv
// Shared types and codes for the cascaded fixed-point IIR filter.
package cfpiir_pkg;

   localparam int COEF_W   = 16;
   localparam int SAMPLE_W = 16;
   localparam int DATA_W   = 32;
   localparam int PROD_W   = DATA_W + COEF_W;
   localparam int CSR_IDX_W = 3;

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2     = 3'd6;

   typedef struct packed {
      logic signed [COEF_W-1:0] lower_limit;
      logic signed [COEF_W-1:0] upper_limit;
      logic signed [COEF_W-1:0] coef_b0;
      logic signed [COEF_W-1:0] coef_b1;
      logic signed [COEF_W-1:0] coef_b2;
      logic signed [COEF_W-1:0] coef_a1;
      logic signed [COEF_W-1:0] coef_a2;
   } cfg_type;

   // Hand-off between neighboring sections: one-cycle valid plus value.
   typedef struct packed {
      logic              vld;
      logic [DATA_W-1:0] value;
   } sec_link_type;

   typedef enum logic [1:0] {
      SEC_IDLE,
      SEC_MUL,
      SEC_ACC
   } sec_state_type;

   // Product terms in issue order.
   typedef enum logic [2:0] {
      TERM_B0,
      TERM_B1,
      TERM_A1,
      TERM_B2,
      TERM_A2
   } term_type;

endpackage

// File: design/cfpiir_section.sv
// One direct-form-I IIR section: history registers and a shared multiply-accumulate.
module cfpiir_section
   import cfpiir_pkg::*;
#(
   parameter int FILTER_ORDER  = 2,
   parameter int FRACTION_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  sec_link_type link_in,
   output sec_link_type link_out
);

   localparam term_type LAST_TERM = (FILTER_ORDER >= 2) ? TERM_A2 : TERM_A1;

   sec_state_type state_ff, state_in;
   term_type      term_ff, term_in;
   logic          done_ff, done_in;
   logic          pvld_ff, pvld_in;
   logic          sub_ff, sub_in;
   logic [DATA_W-1:0] x_ff, x_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] y_ff, y_in;
   logic [DATA_W-1:0] ih_ff [FILTER_ORDER];
   logic [DATA_W-1:0] ih_in [FILTER_ORDER];
   logic [DATA_W-1:0] oh_ff [FILTER_ORDER];
   logic [DATA_W-1:0] oh_in [FILTER_ORDER];

   logic signed [DATA_W-1:0] lower32, upper32;
   logic                     in_range;
   logic signed [DATA_W-1:0] mul_h;
   logic signed [COEF_W-1:0] mul_c;
   logic                     mul_sub;
   logic signed [PROD_W-1:0] prod_full;
   logic [DATA_W-1:0]        sum;
   term_type                 term_next;

   assign lower32  = {{(DATA_W-COEF_W){cfg.lower_limit[COEF_W-1]}}, cfg.lower_limit};
   assign upper32  = {{(DATA_W-COEF_W){cfg.upper_limit[COEF_W-1]}}, cfg.upper_limit};
   assign in_range = ($signed(link_in.value) >= lower32) && ($signed(link_in.value) <= upper32);

   // operand select for the term in flight
   always_comb begin
      case (term_ff)
         TERM_B0: begin
            mul_h = x_ff;                 mul_c = cfg.coef_b0; mul_sub = 1'b0;
         end
         TERM_B1: begin
            mul_h = ih_ff[0];             mul_c = cfg.coef_b1; mul_sub = 1'b0;
         end
         TERM_A1: begin
            mul_h = oh_ff[0];             mul_c = cfg.coef_a1; mul_sub = 1'b1;
         end
         TERM_B2: begin
            mul_h = ih_ff[FILTER_ORDER-1]; mul_c = cfg.coef_b2; mul_sub = 1'b0;
         end
         default: begin
            mul_h = oh_ff[FILTER_ORDER-1]; mul_c = cfg.coef_a2; mul_sub = 1'b1;
         end
      endcase
   end

   always_comb begin
      case (term_ff)
         TERM_B0: term_next = TERM_B1;
         TERM_B1: term_next = TERM_A1;
         TERM_A1: term_next = TERM_B2;
         default: term_next = TERM_A2;
      endcase
   end

   assign prod_full = mul_h * mul_c;
   assign sum = pvld_ff ? (sub_ff ? acc_ff - prod_ff : acc_ff + prod_ff) : acc_ff;

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      done_in  = 1'b0;
      pvld_in  = pvld_ff;
      sub_in   = sub_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      y_in     = y_ff;
      ih_in    = ih_ff;
      oh_in    = oh_ff;
      unique case (state_ff)
         SEC_IDLE: begin
            if (link_in.vld) begin
               x_in = link_in.value;
               if (in_range) begin
                  state_in = SEC_MUL;
                  term_in  = TERM_B0;
                  acc_in   = '0;
                  pvld_in  = 1'b0;
               end else begin
                  // out of limits: pass zero on, history untouched
                  y_in    = '0;
                  done_in = 1'b1;
               end
            end
         end
         SEC_MUL: begin
            prod_in = prod_full[FRACTION_BITS +: DATA_W];
            sub_in  = mul_sub;
            pvld_in = 1'b1;
            acc_in  = sum;
            term_in = term_next;
            if (term_ff == LAST_TERM) begin
               state_in = SEC_ACC;
            end
         end
         SEC_ACC: begin
            y_in = sum;
            for (int k = FILTER_ORDER - 1; k > 0; k--) begin
               ih_in[k] = ih_ff[k-1];
               oh_in[k] = oh_ff[k-1];
            end
            ih_in[0] = x_ff;
            oh_in[0] = sum;
            done_in  = 1'b1;
            state_in = SEC_IDLE;
         end
         default: begin
            state_in = SEC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEC_IDLE;
         done_ff  <= 1'b0;
         for (int k = 0; k < FILTER_ORDER; k++) begin
            ih_ff[k] <= '0;
            oh_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         ih_ff    <= ih_in;
         oh_ff    <= oh_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      pvld_ff <= pvld_in;
      sub_ff  <= sub_in;
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      y_ff    <= y_in;
   end

   assign link_out.vld   = done_ff;
   assign link_out.value = y_ff;

endmodule

// File: design/cascaded_fixed_point_iir_filter.sv
// Top level of the cascaded fixed-point IIR filter: csr bank, section chain, result register.
// Transactions go one at a time: a new request is accepted only after the last result has
// moved into the result register. A section whose input is out of limits passes zero on
// without running its products; a raw sample outside the limits skips the chain. One multiplier
// per section, one product per cycle, sections in turn.
// Reset is synchronous, active high: limits go to full range, coefficients and history to zero.
`include "cascaded_fixed_point_iir_filter_defines.svh"

module cascaded_fixed_point_iir_filter
   import cfpiir_pkg::*;
#(
   parameter int FILTER_ORDER  = 2,
   parameter int SECTION_COUNT = 2,
   parameter int FRACTION_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // input transactions
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_end_of_block,
   // result transactions
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_filtered_value,
   output logic                       rsp_input_rejected,
   output logic                       rsp_final_sample,
   // register writes
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COEF_W-1:0]          csr_write_data
);

   cfg_type cfg_ff, cfg_in;

   // control
   logic busy_ff, busy_in;       // a transaction is inside, not yet in the result register
   logic start_ff, start_in;     // kicks section zero
   logic pend_ff, pend_in;       // result ready, waiting for the result register
   logic pend_rej_ff, pend_rej_in;
   logic rsp_valid_ff, rsp_valid_in;

   // payload
   logic [DATA_W-1:0] x0_ff, x0_in;
   logic              eob_ff, eob_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_rej_ff, rsp_rej_in;
   logic              rsp_eob_ff, rsp_eob_in;

   logic req_acc;
   logic raw_ok;
   logic rsp_free;
   logic load;

   sec_link_type             link [SECTION_COUNT+1];
   logic [SECTION_COUNT:0]   link_vld;

   // ------------------------------------------------------------------
   // Register bank. The user must write only while the filter is idle; the block itself does not enforce it.
   // ------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LOWER_LIMIT: cfg_in.lower_limit = csr_write_data;
            CSR_UPPER_LIMIT: cfg_in.upper_limit = csr_write_data;
            CSR_COEF_B0:     cfg_in.coef_b0     = csr_write_data;
            CSR_COEF_B1:     cfg_in.coef_b1     = csr_write_data;
            CSR_COEF_B2:     cfg_in.coef_b2     = csr_write_data;
            CSR_COEF_A1:     cfg_in.coef_a1     = csr_write_data;
            CSR_COEF_A2:     cfg_in.coef_a2     = csr_write_data;
            default: ;       // unmapped index: write dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Transaction control.
   // ------------------------------------------------------------------
   assign req_ready = !busy_ff;
   assign req_acc   = req_valid && req_ready;
   assign raw_ok    = (req_sample >= cfg_ff.lower_limit) && (req_sample <= cfg_ff.upper_limit);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign load      = pend_ff && rsp_free;

   always_comb begin
      busy_in      = busy_ff;
      start_in     = 1'b0;
      pend_in      = pend_ff;
      pend_rej_in  = pend_rej_ff;
      x0_in        = x0_ff;
      eob_in       = eob_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_eob_in   = rsp_eob_ff;

      if (req_acc) begin
         busy_in = 1'b1;
         eob_in  = req_end_of_block;
         x0_in   = {{(DATA_W-SAMPLE_W){req_sample[SAMPLE_W-1]}}, req_sample};
         if (raw_ok) begin
            start_in = 1'b1;
         end else begin
            // rejected raw sample: skip the chain, no history changes
            pend_in     = 1'b1;
            pend_rej_in = 1'b1;
         end
      end

      // last section finished
      if (link[SECTION_COUNT].vld) begin
         pend_in     = 1'b1;
         pend_rej_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // move the finished result to the output register; the chain frees up
      if (load) begin
         pend_in      = 1'b0;
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_value_in = pend_rej_ff ? '1 : link[SECTION_COUNT].value;
         rsp_rej_in   = pend_rej_ff;
         rsp_eob_in   = eob_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_limit <= 16'sh8000;
         cfg_ff.upper_limit <= 16'sh7fff;
         cfg_ff.coef_b0     <= '0;
         cfg_ff.coef_b1     <= '0;
         cfg_ff.coef_b2     <= '0;
         cfg_ff.coef_a1     <= '0;
         cfg_ff.coef_a2     <= '0;
         busy_ff            <= 1'b0;
         start_ff           <= 1'b0;
         pend_ff            <= 1'b0;
         pend_rej_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         pend_ff      <= pend_in;
         pend_rej_ff  <= pend_rej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff        <= x0_in;
      eob_ff       <= eob_in;
      rsp_value_ff <= rsp_value_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_eob_ff   <= rsp_eob_in;
   end

   // ------------------------------------------------------------------
   // Section chain: each cell hands its output to the next one.
   // The last cell holds its output until it finishes the next transaction.
   // ------------------------------------------------------------------
   assign link[0].vld   = start_ff;
   assign link[0].value = x0_ff;

   for (genvar s = 0; s < SECTION_COUNT; s++) begin : g_sec
      cfpiir_section #(
         .FILTER_ORDER  (FILTER_ORDER),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_section (
         .clock    (clock),
         .reset    (reset),
         .cfg      (cfg_ff),
         .link_in  (link[s]),
         .link_out (link[s+1])
      );
   end

   for (genvar s = 0; s <= SECTION_COUNT; s++) begin : g_vld
      assign link_vld[s] = link[s].vld;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_input_rejected = rsp_rej_ff;
   assign rsp_final_sample   = rsp_eob_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // an accepted transaction blocks the input until its result moves out
   `CFPIIR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // only one section hand-off is in flight at a time
   `CFPIIR_ASSERT_SAME(a_one_handoff, clock, reset, 1'b1, $onehot0(link_vld))
   // the chain only finishes work for a transaction that is inside
   `CFPIIR_ASSERT_SAME(a_done_while_busy, clock, reset, link[SECTION_COUNT].vld, busy_ff && !pend_ff)
   // a pending result goes out as soon as the output register is free
   `CFPIIR_ASSERT_NEXT(a_pend_loads, clock, reset, pend_ff && rsp_free, rsp_valid && !pend_ff)

endmodule
